// ----- design/rfsr_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfsr_pkg
// shared types, codes and defaults for the receive frame slot ring
// ----------------------------------------------------------------------------
package rfsr_pkg;

    localparam int SLOTS_DEF      = 4;
    localparam int SLOT_BYTES_DEF = 1536;
    localparam int MAX_FRAME_W    = 11;
    localparam logic [MAX_FRAME_W-1:0] MAX_FRAME_RST = 11'd1536;
    localparam int BYTE_SHIFT     = 8;

    localparam logic [2:0] OP_START   = 3'd0;
    localparam logic [2:0] OP_WORD    = 3'd1;
    localparam logic [2:0] OP_PEEK    = 3'd2;
    localparam logic [2:0] OP_READ    = 3'd3;
    localparam logic [2:0] OP_RELEASE = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD      = 3'd1;
    localparam logic [2:0] ST_OVERSIZE = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;
    localparam logic [2:0] ST_RANGE    = 3'd5;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic [2:0]  opcode;
        logic        rx_ok;
        logic [15:0] frame_len;
        logic [15:0] data_word;
        logic [9:0]  word_index;
    } t_item;

    typedef struct packed {
        logic [2:0]  status;
        logic        skip_request;
        logic [15:0] head_length;
        logic [15:0] read_word;
        logic [2:0]  frames_held;
    } t_result;

    function automatic logic [15:0] swap_bytes(input logic [15:0] w);
        return {w[BYTE_SHIFT-1:0], w[15:BYTE_SHIFT]};
    endfunction

endpackage

// ----- design/rfsr_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfsr_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module rfsr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/rfsr_ring.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfsr_ring
// slot pointers, fill tracking and the two slot memories; reads at accept,
// updates and writes back on the execute cycle
// ----------------------------------------------------------------------------
module rfsr_ring #(
    parameter int SLOTS      = rfsr_pkg::SLOTS_DEF,
    parameter int SLOT_BYTES = rfsr_pkg::SLOT_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  rfsr_pkg::t_item                  i_item,
    input  logic                             i_exec,
    input  logic                             i_cfg_wr_en,
    input  logic [rfsr_pkg::MAX_FRAME_W-1:0] i_cfg_wr_data,
    output rfsr_pkg::t_result                o_result
);

    localparam int SLOT_WORDS = (SLOT_BYTES + 1) / 2;
    localparam int DEPTH      = SLOTS * SLOT_WORDS;
    localparam int AW         = $clog2(DEPTH);
    localparam int SW         = $clog2(SLOTS);
    localparam int CW         = $clog2(SLOTS + 1);
    localparam int FW         = $clog2(SLOT_WORDS);
    localparam int WLW        = $clog2(SLOT_WORDS + 1);
    localparam logic [AW-1:0] SLOT_WORDS_A = AW'(SLOT_WORDS);
    localparam logic [SW-1:0] LAST_SLOT    = SW'(SLOTS - 1);
    localparam logic [CW-1:0] FULL_COUNT   = CW'(SLOTS);
    localparam logic [15:0]   SLOT_BYTES_L = 16'(SLOT_BYTES);
    localparam logic [16:0]   SLOT_WORDS_L = 17'(SLOT_WORDS);

    rfsr_pkg::t_item                  r_item;
    logic [rfsr_pkg::MAX_FRAME_W-1:0] r_max;
    logic [SW-1:0]                    r_head, n_head;
    logic [SW-1:0]                    r_tail, n_tail;
    logic [CW-1:0]                    r_count, n_count;
    logic                             r_filling, n_filling;
    logic [WLW-1:0]                   r_words_left, n_words_left;
    logic [FW-1:0]                    r_fill, n_fill;

    logic          store_we, len_we;
    logic [AW-1:0] store_waddr, store_raddr;
    logic [15:0]   store_rdata, len_rdata;
    logic [15:0]   limit;
    logic [16:0]   start_words, head_words;
    logic [16:0]   index_ext;
    rfsr_pkg::t_result res;

    // slot memories
    assign store_raddr = r_head * SLOT_WORDS_A + AW'(i_item.word_index);
    assign store_waddr = r_tail * SLOT_WORDS_A + AW'(r_fill);

    rfsr_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (store_waddr),
        .i_wdata (rfsr_pkg::swap_bytes(r_item.data_word)),
        .i_re    (i_accept),
        .i_raddr (store_raddr),
        .o_rdata (store_rdata)
    );

    rfsr_ram #(
        .WIDTH (16),
        .DEPTH (SLOTS)
    ) u_lengths (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (r_tail),
        .i_wdata (r_item.frame_len),
        .i_re    (i_accept),
        .i_raddr (r_head),
        .o_rdata (len_rdata)
    );

    assign limit = (16'(r_max) > SLOT_BYTES_L) ? SLOT_BYTES_L : 16'(r_max);
    assign start_words = ({1'b0, r_item.frame_len} + 17'd1) >> 1;
    assign head_words  = ({1'b0, len_rdata} + 17'd1) >> 1;
    assign index_ext   = 17'(r_item.word_index);

    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_filling    = r_filling;
        n_words_left = r_words_left;
        n_fill       = r_fill;
        store_we     = 1'b0;
        len_we       = 1'b0;
        res          = '0;
        res.status   = rfsr_pkg::ST_OK;
        case (r_item.opcode)
            rfsr_pkg::OP_START: begin
                n_filling    = 1'b0;
                n_words_left = '0;
                n_fill       = '0;
                if (!r_item.rx_ok || r_item.frame_len == 16'd0) begin
                    res.status = rfsr_pkg::ST_BAD;
                end else if (r_item.frame_len > limit) begin
                    res.status       = rfsr_pkg::ST_OVERSIZE;
                    res.skip_request = 1'b1;
                end else if (r_count == FULL_COUNT) begin
                    res.status       = rfsr_pkg::ST_FULL;
                    res.skip_request = 1'b1;
                end else begin
                    len_we       = i_exec;
                    n_words_left = WLW'(start_words);
                    n_filling    = 1'b1;
                end
            end
            rfsr_pkg::OP_WORD: begin
                if (!r_filling || r_words_left == '0) begin
                    res.status = rfsr_pkg::ST_RANGE;
                end else begin
                    store_we     = i_exec;
                    n_fill       = r_fill + FW'(1);
                    n_words_left = r_words_left - WLW'(1);
                    if (r_words_left == WLW'(1)) begin
                        n_filling = 1'b0;
                        n_fill    = '0;
                        n_count   = r_count + CW'(1);
                        n_tail    = (r_tail == LAST_SLOT) ? '0 : r_tail + SW'(1);
                    end
                end
            end
            rfsr_pkg::OP_PEEK: begin
                if (r_count == '0) begin
                    res.status = rfsr_pkg::ST_EMPTY;
                end else begin
                    res.head_length = len_rdata;
                end
            end
            rfsr_pkg::OP_READ: begin
                if (r_count == '0) begin
                    res.status = rfsr_pkg::ST_EMPTY;
                end else begin
                    res.head_length = len_rdata;
                    if (index_ext >= head_words || index_ext >= SLOT_WORDS_L) begin
                        res.status = rfsr_pkg::ST_RANGE;
                    end else begin
                        res.read_word = store_rdata;
                    end
                end
            end
            rfsr_pkg::OP_RELEASE: begin
                if (r_count == '0) begin
                    res.status = rfsr_pkg::ST_EMPTY;
                end else begin
                    n_count = r_count - CW'(1);
                    n_head  = (r_head == LAST_SLOT) ? '0 : r_head + SW'(1);
                end
            end
            default: begin
                res.status = rfsr_pkg::ST_RANGE;
            end
        endcase
        res.frames_held = 3'(n_count);
    end

    assign o_result = res;

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_item <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max        <= rfsr_pkg::MAX_FRAME_RST;
            r_head       <= '0;
            r_tail       <= '0;
            r_count      <= '0;
            r_filling    <= 1'b0;
            r_words_left <= '0;
            r_fill       <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max <= i_cfg_wr_data;
            end
            if (i_exec) begin
                r_head       <= n_head;
                r_tail       <= n_tail;
                r_count      <= n_count;
                r_filling    <= n_filling;
                r_words_left <= n_words_left;
                r_fill       <= n_fill;
            end
        end
    end

endmodule

// ----- design/rx_frame_slot_ring.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rx_frame_slot_ring
// ring of fixed-size receive frame slots with head peek, indexed read and
// release
// ----------------------------------------------------------------------------
// Each item is handled in an accept step and an execute step: in the cycle
// it is accepted the slot data and slot length memories are read (registered
// read), and in the next cycle the ring pointers are updated, any data word or
// length is written back and the result is loaded into the output register.
// A new item is accepted only once the ring is back in idle, so it never takes
// a new item before it is through with the last one. While a result waits on
// the output, no new item is accepted. The slot data memory holds SLOTS slots
// of (SLOT_BYTES + 1) / 2 sixteen-bit words each, the length memory one word
// per slot; neither needs clearing after reset; max_frame_bytes resets to 1536.
// ----------------------------------------------------------------------------
module rx_frame_slot_ring #(
    parameter int SLOTS      = rfsr_pkg::SLOTS_DEF,
    parameter int SLOT_BYTES = rfsr_pkg::SLOT_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [2:0]                       i_opcode,
    input  logic                             i_rx_ok,
    input  logic [15:0]                      i_frame_len,
    input  logic [15:0]                      i_data_word,
    input  logic [9:0]                       i_word_index,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [2:0]                       o_status,
    output logic                             o_skip_request,
    output logic [15:0]                      o_head_length,
    output logic [15:0]                      o_read_word,
    output logic [2:0]                       o_frames_held,
    input  logic                             i_cfg_wr_en,
    input  logic [rfsr_pkg::MAX_FRAME_W-1:0] i_cfg_wr_data
);

    rfsr_pkg::t_state  r_state, n_state;
    rfsr_pkg::t_item   item;
    rfsr_pkg::t_result result;
    rfsr_pkg::t_result r_result;
    logic              r_out_valid, n_out_valid;
    logic              accept, exec;

    assign item.opcode     = i_opcode;
    assign item.rx_ok      = i_rx_ok;
    assign item.frame_len  = i_frame_len;
    assign item.data_word  = i_data_word;
    assign item.word_index = i_word_index;

    rfsr_ring #(
        .SLOTS      (SLOTS),
        .SLOT_BYTES (SLOT_BYTES)
    ) u_ring (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_item        (item),
        .i_exec        (exec),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .o_result      (result)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rfsr_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = rfsr_pkg::S_EXEC;
                end
            end
            rfsr_pkg::S_EXEC: begin
                n_state = rfsr_pkg::S_IDLE;
            end
            default: begin
                n_state = rfsr_pkg::S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_in_ready = 1'b0;
        exec       = 1'b0;
        case (r_state)
            rfsr_pkg::S_IDLE: begin
                o_in_ready = !r_out_valid || i_out_ready;
            end
            rfsr_pkg::S_EXEC: begin
                exec = 1'b1;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    assign accept      = i_in_valid && o_in_ready;
    assign n_out_valid = exec || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rfsr_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_result <= result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_status       = r_result.status;
    assign o_skip_request = r_result.skip_request;
    assign o_head_length  = r_result.head_length;
    assign o_read_word    = r_result.read_word;
    assign o_frames_held  = r_result.frames_held;

endmodule

// ----- design/rfsr_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfsr_checker
// port-level checks for the receive frame slot ring
// ----------------------------------------------------------------------------
module rfsr_checker #(
    parameter int SLOTS = rfsr_pkg::SLOTS_DEF
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  o_status,
    input logic        o_skip_request,
    input logic [15:0] o_head_length,
    input logic [15:0] o_read_word,
    input logic [2:0]  o_frames_held
);

    localparam bit WIDE_RING = (SLOTS >= 8);

    logic in_acc;
    assign in_acc = i_in_valid && o_in_ready;

    // every accepted item yields a registered result after its execute step
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> ##2 o_out_valid)
        else $error("no result after accepted item");

    // one item at a time
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("item accepted while previous one executes");

    // skip only on dropped frames
    a_skip_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_skip_request) |->
        (o_status == rfsr_pkg::ST_OVERSIZE || o_status == rfsr_pkg::ST_FULL))
        else $error("skip request with wrong status");

    // ring never reports more frames than slots (checked for rings of under eight slots)
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (WIDE_RING || o_frames_held <= 3'(SLOTS)))
        else $error("frames held exceeds slot count");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_status) && $stable(o_read_word)
         && $stable(o_head_length) && $stable(o_frames_held)))
        else $error("stalled result changed");

endmodule

bind rx_frame_slot_ring rfsr_checker #(
    .SLOTS (SLOTS)
) u_rfsr_checker (.*);

// ----- sim/rx_frame_slot_ring_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rx_frame_slot_ring_tb
// Self-checking bench for the receive frame slot ring. Frame starts, data
// words, peeks, indexed reads and releases are sent over the item handshake
// with bursty input and a stalling result side. A ring model in the bench
// predicts every result, and the checker compares each returned item field by
// field in order. The run steps through several frame-length limits: zero,
// tiny, random, the slot size and the clamped register maximum.
// ----------------------------------------------------------------------------
module rx_frame_slot_ring_tb;
    import rfsr_pkg::*;

    localparam int SLOT_WORDS = (SLOT_BYTES_DEF + 1) / 2;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SHOWN_MAX = 40;
    localparam logic [2:0] OP_UNUSED_LO = 3'd5;
    localparam logic [2:0] OP_UNUSED_HI = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic [2:0] in_opcode = OP_PEEK;
    logic in_rx_ok = 1'b0;
    logic [15:0] in_frame_len = '0;
    logic [15:0] in_data_word = '0;
    logic [9:0] in_word_index = '0;
    logic out_ready = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [MAX_FRAME_W-1:0] cfg_wr_data = '0;

    logic o_in_ready;
    logic o_out_valid;
    logic [2:0] o_status;
    logic o_skip_request;
    logic [15:0] o_head_length;
    logic [15:0] o_read_word;
    logic [2:0] o_frames_held;

    // ring model state
    logic [15:0] ring_store [SLOTS_DEF*SLOT_WORDS];
    logic [15:0] ring_len [SLOTS_DEF];
    int ring_head = 0;
    int ring_tail = 0;
    int ring_count = 0;
    bit ring_filling = 1'b0;
    int ring_words_left = 0;
    int ring_fill_idx = 0;
    logic [MAX_FRAME_W-1:0] ring_max_bytes = MAX_FRAME_RST;

    t_result ring_replies_due[$];
    int ring_ops_sent = 0;
    int ring_ops_counted = 0;
    int replies_checked = 0;
    int frames_committed = 0;
    int frames_dropped = 0;
    int limits_written = 0;
    int mismatches = 0;
    int cycle_count = 0;
    int burst_left = 0;
    bit gaps_on = 1'b1;

    rx_frame_slot_ring dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (in_valid),
        .o_in_ready     (o_in_ready),
        .i_opcode       (in_opcode),
        .i_rx_ok        (in_rx_ok),
        .i_frame_len    (in_frame_len),
        .i_data_word    (in_data_word),
        .i_word_index   (in_word_index),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (out_ready),
        .o_status       (o_status),
        .o_skip_request (o_skip_request),
        .o_head_length  (o_head_length),
        .o_read_word    (o_read_word),
        .o_frames_held  (o_frames_held),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: always ready, random, periodic and heavy stall stretches
    always @(posedge i_clk) begin
        case (cycle_count[10:9])
            2'd0: out_ready <= 1'b1;
            2'd1: out_ready <= ($urandom_range(0, 3) != 0);
            2'd2: out_ready <= ((cycle_count % 5) >= 2);
            default: out_ready <= ($urandom_range(0, 9) < 4);
        endcase
    end

    function automatic int frame_limit();
        return (ring_max_bytes > SLOT_BYTES_DEF) ? SLOT_BYTES_DEF : int'(ring_max_bytes);
    endfunction

    function automatic int next_ring_slot(input int s);
        return (s + 1 >= SLOTS_DEF) ? 0 : s + 1;
    endfunction

    function automatic t_result predict_ring_step(input t_item it);
        t_result r;
        int hw;
        r = '0;
        r.status = ST_OK;
        case (it.opcode)
            OP_START: begin
                ring_filling = 1'b0;
                ring_words_left = 0;
                ring_fill_idx = 0;
                if (!it.rx_ok || it.frame_len == 16'd0) begin
                    r.status = ST_BAD;
                end else if (int'(it.frame_len) > frame_limit()) begin
                    r.status = ST_OVERSIZE;
                    r.skip_request = 1'b1;
                    frames_dropped++;
                end else if (ring_count >= SLOTS_DEF) begin
                    r.status = ST_FULL;
                    r.skip_request = 1'b1;
                    frames_dropped++;
                end else begin
                    ring_len[ring_tail] = it.frame_len;
                    ring_words_left = (int'(it.frame_len) + 1) / 2;
                    ring_filling = 1'b1;
                end
            end
            OP_WORD: begin
                if (!ring_filling || ring_words_left == 0 || ring_fill_idx >= SLOT_WORDS) begin
                    r.status = ST_RANGE;
                end else begin
                    ring_store[ring_tail*SLOT_WORDS + ring_fill_idx] =
                        {it.data_word[7:0], it.data_word[15:8]};
                    ring_fill_idx++;
                    ring_words_left--;
                    if (ring_words_left == 0) begin
                        ring_filling = 1'b0;
                        ring_fill_idx = 0;
                        ring_count++;
                        ring_tail = next_ring_slot(ring_tail);
                        frames_committed++;
                    end
                end
            end
            OP_PEEK: begin
                if (ring_count == 0) r.status = ST_EMPTY;
                else r.head_length = ring_len[ring_head];
            end
            OP_READ: begin
                if (ring_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.head_length = ring_len[ring_head];
                    hw = (int'(ring_len[ring_head]) + 1) / 2;
                    if (int'(it.word_index) >= hw || int'(it.word_index) >= SLOT_WORDS)
                        r.status = ST_RANGE;
                    else
                        r.read_word = ring_store[ring_head*SLOT_WORDS + int'(it.word_index)];
                end
            end
            OP_RELEASE: begin
                if (ring_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    ring_count--;
                    ring_head = next_ring_slot(ring_head);
                end
            end
            default: r.status = ST_RANGE;
        endcase
        r.frames_held = ring_count[2:0];
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            mismatches++;
            if (mismatches <= SHOWN_MAX)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (ring_replies_due.size() == 0) begin
                mismatches++;
                if (mismatches <= SHOWN_MAX)
                    $display("%0t: unexpected item, expected none, got status %0h",
                             $time, o_status);
            end else begin
                want = ring_replies_due.pop_front();
                replies_checked++;
                check_field("status", 16'(want.status), 16'(o_status));
                check_field("skip_request", 16'(want.skip_request), 16'(o_skip_request));
                check_field("head_length", want.head_length, o_head_length);
                check_field("read_word", want.read_word, o_read_word);
                check_field("frames_held", 16'(want.frames_held), 16'(o_frames_held));
            end
        end
    end

    task automatic send_item(input t_item it);
        t_result r;
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (gaps_on && $urandom_range(0, 2) != 0) ? $urandom_range(1, 8) : 0;
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_opcode <= it.opcode;
        in_rx_ok <= it.rx_ok;
        in_frame_len <= it.frame_len;
        in_data_word <= it.data_word;
        in_word_index <= it.word_index;
        do @(posedge i_clk); while (!o_in_ready);
        r = predict_ring_step(it);
        ring_replies_due.push_back(r);
        ring_ops_sent++;
        if (it.opcode <= OP_RELEASE && r.status != ST_BAD)
            ring_ops_counted++;
    endtask

    function automatic t_item rand_item(input logic [2:0] op);
        t_item it;
        it.opcode = op;
        it.rx_ok = 1'($urandom_range(0, 1));
        it.frame_len = 16'($urandom_range(0, 16'hFFFF));
        it.data_word = 16'($urandom_range(0, 16'hFFFF));
        it.word_index = 10'($urandom_range(0, 10'h3FF));
        return it;
    endfunction

    task automatic send_op(input logic [2:0] op);
        send_item(rand_item(op));
    endtask

    task automatic send_start(input logic ok, input logic [15:0] len);
        t_item it;
        it = rand_item(OP_START);
        it.rx_ok = ok;
        it.frame_len = len;
        send_item(it);
    endtask

    task automatic send_word(input logic [15:0] w);
        t_item it;
        it = rand_item(OP_WORD);
        it.data_word = w;
        send_item(it);
    endtask

    task automatic send_read(input logic [9:0] idx);
        t_item it;
        it = rand_item(OP_READ);
        it.word_index = idx;
        send_item(it);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        while (ring_replies_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_max_frame(input logic [MAX_FRAME_W-1:0] v);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en <= 1'b0;
        ring_max_bytes = v;
        limits_written++;
    endtask

    function automatic logic [9:0] pick_head_index();
        int hw;
        if (ring_count == 0) return 10'($urandom_range(0, 10'h3FF));
        hw = (int'(ring_len[ring_head]) + 1) / 2;
        case ($urandom_range(0, 7))
            0: return 10'($urandom_range(0, 10'h3FF));
            1: return (hw < 1024) ? 10'(hw) : 10'h3FF;
            default: return 10'($urandom_range(0, hw - 1));
        endcase
    endfunction

    task automatic send_frame();
        int lim;
        int span;
        int len;
        int nwords;
        int stop_at;
        lim = frame_limit();
        if (lim == 0) begin
            send_start(1'b1, 16'($urandom_range(1, 16'hFFFF)));
            return;
        end
        span = (lim < 48) ? lim : 48;
        len = ($urandom_range(0, 39) == 0) ? $urandom_range(1, lim) : $urandom_range(1, span);
        nwords = (len + 1) / 2;
        stop_at = ($urandom_range(0, 15) == 0) ? $urandom_range(0, nwords - 1) : nwords;
        send_start(1'b1, 16'(len));
        for (int i = 0; i < stop_at; i++) send_word(16'($urandom_range(0, 16'hFFFF)));
        if (stop_at != nwords) return;
        repeat ($urandom_range(0, 3)) send_read(pick_head_index());
        if ($urandom_range(0, 1) != 0) send_op(OP_PEEK);
        if ($urandom_range(0, 9) < 6) send_op(OP_RELEASE);
    endtask

    task automatic run_traffic(input int n_ops);
        int base;
        int sel;
        int lim;
        base = ring_ops_counted;
        while (ring_ops_counted - base < n_ops) begin
            sel = $urandom_range(0, 99);
            lim = frame_limit();
            if (sel < 60) begin
                send_frame();
            end else if (sel < 66) begin
                send_start(1'b0, 16'($urandom_range(0, 16'hFFFF)));
            end else if (sel < 68) begin
                send_start(1'b1, 16'd0);
            end else if (sel < 74) begin
                send_start(1'b1, 16'($urandom_range(lim + 1, 16'hFFFF)));
            end else if (sel < 80) begin
                send_word(16'($urandom_range(0, 16'hFFFF)));
            end else if (sel < 84) begin
                send_op(3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)));
            end else if (sel < 92) begin
                send_read(pick_head_index());
            end else begin
                send_op(($urandom_range(0, 1) != 0) ? OP_PEEK : OP_RELEASE);
            end
        end
    endtask

    task automatic test_empty_ring();
        send_op(OP_PEEK);
        send_read(10'd0);
        send_op(OP_RELEASE);
        send_word(16'hFFFF);
        send_op(OP_UNUSED_LO);
        send_op(OP_UNUSED_HI);
    endtask

    task automatic test_bad_frames();
        send_start(1'b0, 16'd100);
        send_start(1'b1, 16'd0);
        send_start(1'b1, 16'hFFFF);
        send_start(1'b1, 16'(SLOT_BYTES_DEF + 1));
    endtask

    task automatic test_fill_and_read();
        send_start(1'b1, 16'd5);
        send_word(16'h1234);
        // restart abandons the partial frame
        send_start(1'b1, 16'd3);
        send_word(16'hFFFF);
        send_word(16'h00FF);
        send_word(16'hA5C3);
        send_op(OP_PEEK);
        send_read(10'd0);
        send_read(10'd1);
        send_read(10'h3FF);
    endtask

    task automatic test_full_ring();
        repeat (SLOTS_DEF - 1) begin
            send_start(1'b1, 16'd1);
            send_word(16'($urandom_range(0, 16'hFFFF)));
        end
        send_start(1'b1, 16'd2);
        send_word(16'h0000);
        repeat (SLOTS_DEF + 1) send_op(OP_RELEASE);
    endtask

    task automatic test_largest_frame();
        write_max_frame(11'h7FF);
        while (ring_count != 0) send_op(OP_RELEASE);
        send_start(1'b1, 16'(SLOT_BYTES_DEF + 1));
        send_start(1'b1, 16'(SLOT_BYTES_DEF));
        repeat (SLOT_WORDS) send_word(16'($urandom_range(0, 16'hFFFF)));
        send_read(10'(SLOT_WORDS - 1));
        send_read(10'(SLOT_WORDS));
        send_read(10'd0);
        repeat (6) send_read(10'($urandom_range(0, SLOT_WORDS - 1)));
        send_op(OP_RELEASE);
    endtask

    task automatic test_limit_settings();
        write_max_frame(11'd0);
        run_traffic(50);
        write_max_frame(11'd1);
        run_traffic(50);
        write_max_frame(11'd2);
        run_traffic(50);
        write_max_frame(11'($urandom_range(3, SLOT_BYTES_DEF - 1)));
        run_traffic(50);
        write_max_frame(11'd1535);
        run_traffic(50);
    endtask

    task automatic test_random_traffic();
        write_max_frame(MAX_FRAME_RST);
        run_traffic(150);
        // hold off until the ring has answered everything
        wait_idle();
        gaps_on = 1'b0;
        run_traffic(80);
        gaps_on = 1'b1;
        run_traffic(80);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_ring();
        test_bad_frames();
        test_fill_and_read();
        test_full_ring();
        test_largest_frame();
        test_limit_settings();
        test_random_traffic();
        wait_idle();
        $display("run: %0d items sent, %0d results checked, %0d mismatches",
                 ring_ops_sent, replies_checked, mismatches);
        $display("run: %0d frames committed, %0d dropped, %0d limit writes, %0d cycles",
                 frames_committed, frames_dropped, limits_written, cycle_count);
        if (mismatches == 0 && ring_replies_due.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
design/rfsr_pkg.sv
design/rfsr_ram.sv
design/rfsr_ring.sv
design/rx_frame_slot_ring.sv
design/rfsr_checker.sv
sim/rx_frame_slot_ring_tb.sv
